// ===== src/puac_pkg.sv =====
package puac_pkg;

  localparam int ID_W        = 10;
  localparam int CNT_W       = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic [1:0] {
    OP_INC = 2'd0,
    OP_DEC = 2'd1,
    OP_CLR = 2'd2,
    OP_QRY = 2'd3
  } op_t;

  // Counts of one entry together with the totals
  typedef struct packed {
    logic             rejected;
    logic [CNT_W-1:0] all_peak;
    logic [CNT_W-1:0] all_used;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] used;
  } acct_t;

endpackage

// ===== src/puac_ram.sv =====
module puac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/puac_calc.sv =====
module puac_calc (
  input  puac_pkg::op_t                 op,
  input  logic [puac_pkg::CNT_W-1:0]    amt,
  input  puac_pkg::acct_t               cur,
  output puac_pkg::acct_t               nxt
);

  always_comb begin
    logic [puac_pkg::CNT_W:0] u_sum;
    logic [puac_pkg::CNT_W:0] t_sum;
    u_sum = {1'b0, cur.used} + {1'b0, amt};
    t_sum = {1'b0, cur.all_used} + {1'b0, amt};
    nxt = cur;
    nxt.rejected = 1'b0;
    unique case (op)
      puac_pkg::OP_INC: begin
        // saturate at all ones on carry out
        nxt.used     = u_sum[puac_pkg::CNT_W] ? '1 : u_sum[puac_pkg::CNT_W-1:0];
        nxt.all_used = t_sum[puac_pkg::CNT_W] ? '1 : t_sum[puac_pkg::CNT_W-1:0];
        nxt.peak     = (nxt.used > cur.peak) ? nxt.used : cur.peak;
        nxt.all_peak = (nxt.all_used > cur.all_peak) ? nxt.all_used : cur.all_peak;
      end
      puac_pkg::OP_DEC: begin
        if (cur.used < amt) begin
          nxt.rejected = 1'b1;
        end else begin
          nxt.used     = cur.used - amt;
          // total may lag the entries after saturation or a clear
          nxt.all_used = (cur.all_used < amt) ? '0 : cur.all_used - amt;
        end
      end
      puac_pkg::OP_CLR: begin
        nxt.used = '0;
        nxt.peak = '0;
      end
      puac_pkg::OP_QRY: begin
      end
    endcase
  end

endmodule

// ===== src/per_id_usage_peak_accounting.sv =====
// Per-requester byte accounting. Each transfer on the input stream names an
// operation (increase, decrease, clear, query), a requester and a byte count,
// and yields exactly one result transfer with that entry's used and peak
// counts and the overall used and peak totals after the step. Requester ids
// past the last entry are clamped to it. One item is taken per clock unless the
// output stalls; inputs register in stage 1 with the table read, results in the
// output register. The rate is set by the single read-modify-write of the
// entry table (one read and one write port, with the previous write forwarded).
// After reset a pass zeroes the table, during which s_axis_tready is low.
module per_id_usage_peak_accounting #(
  parameter int ENTRY_COUNT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[1:0], requester_id[11:2], amount[43:12], zero fill
  input  logic [puac_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // entry_used[31:0], entry_peak[63:32], all_used[95:64], all_peak[127:96],
  // decrease_rejected[128], zero fill
  output logic [puac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam int CW = puac_pkg::CNT_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRY_COUNT - 1);

  // input fields
  puac_pkg::op_t               in_op;
  logic [puac_pkg::ID_W-1:0]   in_id;
  logic [CW-1:0]               in_amt;
  logic [AW-1:0]               rd_addr;

  // control
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          accept;
  logic          advance;
  logic          fire;

  // stage 1
  logic            s1_valid;
  puac_pkg::op_t   s1_op;
  logic [AW-1:0]   s1_addr;
  logic [CW-1:0]   s1_amt;
  logic            s1_fwd;
  logic [2*CW-1:0] s1_fwd_data;

  // table port
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [2*CW-1:0] wr_data;
  logic [2*CW-1:0] rd_data;
  logic [2*CW-1:0] entry;

  logic [CW-1:0]   all_used;
  logic [CW-1:0]   all_peak;

  puac_pkg::acct_t cur;
  puac_pkg::acct_t nxt;

  logic            out_valid;
  puac_pkg::acct_t out_acct;

  assign in_op  = puac_pkg::op_t'(s_axis_tdata[1:0]);
  assign in_id  = s_axis_tdata[11:2];
  assign in_amt = s_axis_tdata[43:12];

  assign rd_addr = (32'(in_id) > ENTRY_COUNT - 1) ? LAST : in_id[AW-1:0];

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = s1_valid && advance;
  assign s_axis_tready = !clearing && (!s1_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign wr_en   = clearing || fire;
  assign wr_addr = clearing ? clr_addr : s1_addr;
  assign wr_data = clearing ? '0 : {nxt.peak, nxt.used};

  puac_ram #(
    .WIDTH(2 * CW),
    .DEPTH(ENTRY_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // a write landing on the same edge as the read is not seen by the RAM
  assign entry = s1_fwd ? s1_fwd_data : rd_data;

  always_comb begin
    cur.used     = entry[CW-1:0];
    cur.peak     = entry[2*CW-1:CW];
    cur.all_used = all_used;
    cur.all_peak = all_peak;
    cur.rejected = 1'b0;
  end

  puac_calc u_calc (
    .op (s1_op),
    .amt(s1_amt),
    .cur(cur),
    .nxt(nxt)
  );

  // zeroing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= in_op;
      s1_addr     <= rd_addr;
      s1_amt      <= in_amt;
      s1_fwd      <= wr_en && (wr_addr == rd_addr);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_used <= '0;
      all_peak <= '0;
    end else if (fire) begin
      all_used <= nxt.all_used;
      all_peak <= nxt.all_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_acct <= nxt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_acct};

  a_total_peak: assert property (@(posedge clk) disable iff (rst)
    all_peak >= all_used)
    else $error("total peak below total in use");

  a_entry_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_acct.peak >= out_acct.used))
    else $error("entry peak below entry in use");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !out_valid))
    else $error("item in flight during table clear");

endmodule
